>>> rtl/core/assert_macros.svh
// Assertion macros for the colormap RTL.
// Included by the top-level unit, which checks its own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
    else $error(msg);

// Implication checked on the next clock edge.
`define ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
    (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/scrgb_pkg.sv
// Shared types and codes for the scalar-to-RGB colormap.
// No dependencies; used by the map datapath and the top level.
package scrgb_pkg;

  typedef enum logic [1:0] {
    MODE_BLUE_HOT  = 2'd0,
    MODE_DIVERGENT = 2'd1,
    MODE_HSV       = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam logic [7:0] CHAN_MAX  = 8'd255;
  localparam logic [7:0] CHAN_HALF = 8'd128;

endpackage

>>> rtl/core/scrgb_if.sv
// Valid/ready channel interfaces for the colormap: scalar words in, color words out.
// Depends on nothing; the scalar width follows FRAC_BITS.
interface scrgb_scalar_if #(
  parameter int FRAC_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS:0]   scalar_in;

  modport source (output valid, output scalar_in, input ready);
  modport sink   (input valid, input scalar_in, output ready);
endinterface

interface scrgb_color_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/core/scrgb_map.sv
// Combinational colormap datapath: blue hot, divergent and HSV rainbow maps.
// Depends on scrgb_pkg; expects the scalar already saturated to one.
module scrgb_map #(
  parameter int FRAC_BITS = 16
) (
  input  logic [FRAC_BITS:0] scalar,
  input  scrgb_pkg::mode_t   mode,
  output scrgb_pkg::rgb_t    color
);

  localparam int SW = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + 9;
  localparam int HW = FRAC_BITS + 3;
  localparam logic [SW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SW-1:0] HALF = ONE >> 1;
  localparam logic [PW-1:0] ROUND_UP = PW'(ONE) - PW'(1);

  // Blue hot.
  logic [PW-1:0] p255_s, p127_s;
  logic [7:0]    bh_rg, bh_b;

  // Divergent: d is twice the distance from the lower end of its half.
  logic          below_half, at_half;
  logic [SW-1:0] d;
  logic [PW-1:0] p255_d, p127_d, c255_d, c127_d;

  // HSV rainbow.
  logic [HW-1:0]        hue;
  logic [2:0]           sector;
  logic [FRAC_BITS-1:0] frac;
  logic [PW-1:0]        p255_r, c255_r;
  logic [7:0]           up, down;

  assign p255_s = PW'(scalar) * PW'(255);
  assign p127_s = PW'(scalar) * PW'(127);
  assign bh_rg  = p255_s[FRAC_BITS +: 8];
  assign bh_b   = scrgb_pkg::CHAN_HALF + p127_s[FRAC_BITS +: 8];

  assign below_half = scalar < HALF;
  assign at_half    = scalar == HALF;
  assign d          = below_half ? (scalar << 1) : ((scalar - HALF) << 1);
  assign p255_d     = PW'(d) * PW'(255);
  assign p127_d     = PW'(d) * PW'(127);
  assign c255_d     = p255_d + ROUND_UP;
  assign c127_d     = p127_d + ROUND_UP;

  assign hue    = HW'(scalar) * HW'(6);
  assign sector = hue[FRAC_BITS +: 3];
  assign frac   = hue[FRAC_BITS-1:0];
  assign p255_r = PW'(frac) * PW'(255);
  assign c255_r = p255_r + ROUND_UP;
  assign up     = p255_r[FRAC_BITS +: 8];
  assign down   = scrgb_pkg::CHAN_MAX - c255_r[FRAC_BITS +: 8];

  always_comb begin
    color = '0;
    case (mode)
      scrgb_pkg::MODE_BLUE_HOT: begin
        color.red   = bh_rg;
        color.green = bh_rg;
        color.blue  = bh_b;
      end
      scrgb_pkg::MODE_DIVERGENT: begin
        if (below_half) begin
          color.red   = p255_d[FRAC_BITS +: 8];
          color.green = p255_d[FRAC_BITS +: 8];
          color.blue  = scrgb_pkg::CHAN_HALF + p127_d[FRAC_BITS +: 8];
        end else if (at_half) begin
          color.red   = scrgb_pkg::CHAN_MAX;
          color.green = scrgb_pkg::CHAN_MAX;
          color.blue  = scrgb_pkg::CHAN_MAX;
        end else begin
          color.red   = scrgb_pkg::CHAN_MAX - c127_d[FRAC_BITS +: 8];
          color.green = scrgb_pkg::CHAN_MAX - c255_d[FRAC_BITS +: 8];
          color.blue  = scrgb_pkg::CHAN_MAX - c255_d[FRAC_BITS +: 8];
        end
      end
      scrgb_pkg::MODE_HSV: begin
        // Sector six only occurs at exactly one and wraps back to red.
        case (sector)
          3'd0: begin
            color.red = scrgb_pkg::CHAN_MAX; color.green = up;   color.blue = 8'd0;
          end
          3'd1: begin
            color.red = down; color.green = scrgb_pkg::CHAN_MAX; color.blue = 8'd0;
          end
          3'd2: begin
            color.red = 8'd0; color.green = scrgb_pkg::CHAN_MAX; color.blue = up;
          end
          3'd3: begin
            color.red = 8'd0; color.green = down; color.blue = scrgb_pkg::CHAN_MAX;
          end
          3'd4: begin
            color.red = up;   color.green = 8'd0; color.blue = scrgb_pkg::CHAN_MAX;
          end
          3'd5: begin
            color.red = scrgb_pkg::CHAN_MAX; color.green = 8'd0; color.blue = down;
          end
          default: begin
            color.red = scrgb_pkg::CHAN_MAX; color.green = 8'd0; color.blue = 8'd0;
          end
        endcase
      end
      default: begin
        color = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/scalar_to_rgb_colormap_unit.sv
// An accepted word is held in the input register, then mapped into the color register that drives the output.
// Throughput: one word per cycle; the input register and the color register
// form a two-stage pipeline that stalls only while the output is held off.
// Reset (synchronous, active low) empties both stages and selects blue hot.
// Depends on scrgb_pkg, scrgb_if.sv, scrgb_map and assert_macros.svh.
module scalar_to_rgb_colormap_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  scrgb_scalar_if.sink         in_stream,
  scrgb_color_if.source        out_stream,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata
);

  `include "assert_macros.svh"

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  scrgb_pkg::mode_t   map_mode_r;
  logic               s1_valid_r;
  logic [FRAC_BITS:0] s1_scalar_r, s1_scalar_nxt;
  logic               out_valid_r;
  scrgb_pkg::rgb_t    out_color_r, out_color_nxt;
  logic               out_adv, in_ready;
  logic               in_fire, s1_fire;
  logic               hsv_out, hsv_full, bh_out, bh_shape;

  assign out_adv  = !out_valid_r || out_stream.ready;
  assign in_ready = !s1_valid_r || out_adv;

  // Scalars above one are clipped before they are registered.
  assign s1_scalar_nxt = (in_stream.scalar_in > ONE) ? ONE : in_stream.scalar_in;

  scrgb_map #(
    .FRAC_BITS (FRAC_BITS)
  ) u_map (
    .scalar (s1_scalar_r),
    .mode   (map_mode_r),
    .color  (out_color_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_mode_r  <= scrgb_pkg::MODE_BLUE_HOT;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        map_mode_r <= scrgb_pkg::mode_t'(cfg_wdata);
      end
      if (in_ready) begin
        s1_valid_r <= in_stream.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_stream.valid) begin
      s1_scalar_r <= s1_scalar_nxt;
    end
    if (out_adv && s1_valid_r) begin
      out_color_r <= out_color_nxt;
    end
  end

  assign in_stream.ready  = in_ready;
  assign out_stream.valid = out_valid_r;
  assign out_stream.red   = out_color_r.red;
  assign out_stream.green = out_color_r.green;
  assign out_stream.blue  = out_color_r.blue;

  assign in_fire  = in_stream.valid && in_ready;
  assign s1_fire  = s1_valid_r && out_adv;
  assign hsv_out  = out_valid_r && (map_mode_r == scrgb_pkg::MODE_HSV);
  assign hsv_full = (out_color_r.red == scrgb_pkg::CHAN_MAX) ||
                    (out_color_r.green == scrgb_pkg::CHAN_MAX) ||
                    (out_color_r.blue == scrgb_pkg::CHAN_MAX);
  assign bh_out   = out_valid_r && (map_mode_r == scrgb_pkg::MODE_BLUE_HOT);
  assign bh_shape = (out_color_r.red == out_color_r.green) &&
                    (out_color_r.blue >= scrgb_pkg::CHAN_HALF);

  `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_fire, s1_valid_r, "accepted word lost")
  `ASSERT_NEXT(a_s1_moves_out, clk, rst_n, s1_fire, out_valid_r, "stage word not passed")
  `ASSERT_CLK(a_hsv_full_value, clk, rst_n, !hsv_out || hsv_full, "no full HSV channel")
  `ASSERT_CLK(a_blue_hot_shape, clk, rst_n, !bh_out || bh_shape, "blue hot out of shape")

endmodule
